[design/aes128_block_encrypt_assert.svh]
// assertion macros for the aes128 block encrypt checker
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define AES_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[design/aes_pkg.sv]
// shared types, constants and functions for the aes128 block encrypt
package aes_pkg;
   localparam int NumRounds = 10;
   localparam int CsrIdxW = 8;
   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW = 8'd1;

   typedef logic [127:0] block_type;

   // forward s-box
   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // byte k of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type b, input int k);
      get_byte = b[127-8*k -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // subbytes then shiftrows
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127-8*(4*c) -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction

   // next round key from the previous one
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      block_type n;
      logic [31:0] t;
      t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      n[127:96] = k[127:96] ^ t;
      n[95:64] = k[95:64] ^ n[127:96];
      n[63:32] = k[63:32] ^ n[95:64];
      n[31:0] = k[31:0] ^ n[63:32];
      next_key = n;
   endfunction
endpackage

[design/aes_key_expand.sv]
// round key expansion: one round key register per pipeline stage but the last
module aes_key_expand
   import aes_pkg::*;
(
   input  logic      clock,
   input  logic      adv,
   input  logic [127:0] key,
   output block_type round_key [NumRounds+1]
);
   // key of each stage moves with the block in that stage, so every request
   // keeps the key that was current when it was accepted
   block_type rk_ff [NumRounds];
   logic [7:0] rcon [NumRounds];

   always_comb begin
      rcon[0] = 8'h01;
      for (int i = 1; i < NumRounds; i++) begin
         rcon[i] = xtime(rcon[i-1]);
      end
   end

   // round key of a stage derived from the key held one stage earlier
   always_comb begin
      round_key[0] = key;
      for (int i = 1; i <= NumRounds; i++) begin
         round_key[i] = next_key(rk_ff[i-1], rcon[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NumRounds; i++) rk_ff[i] <= round_key[i];
      end
   end
endmodule

[design/aes128_block_encrypt.sv]
// aes128 block encrypt: one round per pipeline stage
// the valid bit moves through vld_ff[0] to vld_ff[10] beside the data; rsp_valid is vld_ff[10]
// throughput: one block per cycle while the output is not stalled; eleven stages, initial key add then ten rounds
// a stall freezes every stage; valid bits and round keys move with the data
// synchronous reset clears the key to zero and all valid bits
// each request uses the key held when it is accepted
module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [63:0]  req_plain_high,
   input  logic [63:0]  req_plain_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_cipher_high,
   output logic [63:0]  rsp_cipher_low,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [63:0]  csr_data
);
   logic [63:0] key_high_ff, key_low_ff;
   block_type   round_key [NumRounds+1];
   block_type   st_ff [NumRounds+1];
   logic        vld_ff [NumRounds+1];
   logic        adv;

   assign csr_ready = 1'b1;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   aes_key_expand u_key (
      .clock     (clock),
      .adv       (adv),
      .key       ({key_high_ff, key_low_ff}),
      .round_key (round_key)
   );

   // whole pipe advances unless the output stage is held
   assign adv = !(vld_ff[NumRounds] && rsp_stall);
   assign req_stall = !adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NumRounds; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= NumRounds; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // round stages
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= {req_plain_high, req_plain_low} ^ round_key[0];
         for (int i = 1; i < NumRounds; i++) begin
            st_ff[i] <= mix_columns(sub_shift(st_ff[i-1])) ^ round_key[i];
         end
         st_ff[NumRounds] <= sub_shift(st_ff[NumRounds-1]) ^ round_key[NumRounds];
      end
   end

   assign rsp_valid = vld_ff[NumRounds];
   assign rsp_cipher_high = st_ff[NumRounds][127:64];
   assign rsp_cipher_low = st_ff[NumRounds][63:0];
endmodule

[design/aes_checker.sv]
// port-level checker for the aes128 block encrypt, bound to the top level
`include "aes128_block_encrypt_assert.svh"
module aes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_cipher_high,
   input logic [63:0] rsp_cipher_low
);
   // a held result keeps its payload
   `AES_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_valid && $stable({rsp_cipher_high, rsp_cipher_low}))
   // input is stalled only while a result is held
   `AES_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // an unstalled output never blocks the input
   `AES_ASSERT_IMP(a_drain, clock, reset, !rsp_stall, !req_stall)
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_cipher_high (rsp_cipher_high),
   .rsp_cipher_low  (rsp_cipher_low)
);

[tb/tb_aes128_block_encrypt.sv]
// self-checking testbench for the aes128 block encrypt pipeline
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;
   import aes_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int KeySettle = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   aes128_block_encrypt dut (.*);

   always #5 clock = ~clock;

   // predictor state: cipher key, expanded round keys, substitution table
   logic [63:0] key_hi_q, key_lo_q;
   logic [127:0] round_keys [11];
   logic [7:0] sub_lut [256];
   logic [127:0] expected_ciphers [$];
   int errors = 0;
   int blocks_sent = 0;
   int ciphers_seen = 0;
   int keys_used = 0;
   int cycles = 0;
   int hold_left = 0;
   bit stall_random = 1'b0;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // s-box from the field inverse and the affine map
   task automatic build_sub_lut();
      logic [7:0] inv, r, t;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_product(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         r = 8'h63 ^ inv;
         t = inv;
         for (int i = 0; i < 4; i++) begin
            t = {t[6:0], t[7]};
            r ^= t;
         end
         sub_lut[x] = r;
      end
   endtask

   // key schedule from the current key registers
   task automatic expand_round_keys();
      logic [31:0] w [44];
      logic [31:0] tmp;
      logic [7:0] rc;
      logic [127:0] k;
      rc = 8'h01;
      k = {key_hi_q, key_lo_q};
      for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         tmp = w[i-1];
         if (i % 4 == 0) begin
            tmp = {sub_lut[tmp[23:16]] ^ rc, sub_lut[tmp[15:8]], sub_lut[tmp[7:0]],
                   sub_lut[tmp[31:24]]};
            rc = gf_double(rc);
         end
         w[i] = w[i-4] ^ tmp;
      end
      for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endtask

   function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
      logic [127:0] s, t;
      logic [7:0] a0, a1, a2, a3, all;
      s = plain ^ round_keys[0];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // substitute bytes and rotate rows
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               t[127-8*(4*c+r) -: 8] = sub_lut[s[127-8*(4*((c+r)%4)+r) -: 8]];
            end
         end
         s = t;
         // column mixing except in the last round
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[127-32*c -: 8];
               a1 = s[119-32*c -: 8];
               a2 = s[111-32*c -: 8];
               a3 = s[103-32*c -: 8];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[127-32*c -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
               t[119-32*c -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
               t[111-32*c -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
               t[103-32*c -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
            s = t;
         end
         s ^= round_keys[rnd];
      end
      return s;
   endfunction

   // cycle counter and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d ciphers outstanding", cycles,
                  expected_ciphers.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (stall_random) begin
         rsp_stall <= ($urandom_range(0, 3) == 0) || (($urandom_range(0, 63) == 0));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ciphers_seen <= ciphers_seen + 1;
         if (expected_ciphers.size() == 0) begin
            $display("%0t: unexpected result high=%h low=%h", $realtime,
                     rsp_cipher_high, rsp_cipher_low);
            errors <= errors + 1;
         end else begin
            if (rsp_cipher_high !== expected_ciphers[0][127:64]) begin
               $display("%0t: cipher_high expected %h actual %h", $realtime,
                        expected_ciphers[0][127:64], rsp_cipher_high);
               errors <= errors + 1;
            end
            if (rsp_cipher_low !== expected_ciphers[0][63:0]) begin
               $display("%0t: cipher_low expected %h actual %h", $realtime,
                        expected_ciphers[0][63:0], rsp_cipher_low);
               errors <= errors + 1;
            end
            void'(expected_ciphers.pop_front());
         end
      end
   end

   // offer one request and hold it until accepted
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      @(negedge clock);
      req_valid <= 1'b1;
      req_plain_high <= hi;
      req_plain_low <= lo;
      do @(posedge clock); while (req_stall);
      expected_ciphers.push_back(encrypt_block({hi, lo}));
      blocks_sent++;
   endtask

   task automatic idle_sender(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_sender(0);
      while (expected_ciphers.size() != 0) @(posedge clock);
      repeat (KeySettle) @(posedge clock);
   endtask

   // register write once the pipeline is empty, then let the round keys settle
   task automatic write_key_reg(input logic [CsrIdxW-1:0] idx, input logic [63:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_HIGH) key_hi_q = value;
      else if (idx == CSR_KEY_LOW) key_lo_q = value;
      expand_round_keys();
      keys_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
      repeat (KeySettle) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      write_key_reg(CSR_KEY_HIGH, hi);
      write_key_reg(CSR_KEY_LOW, lo);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // reset key, then the standard published vector
   task automatic test_standard_vector();
      send_block(64'h0, 64'h0);
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      if (encrypt_block({64'h0011223344556677, 64'h8899aabbccddeeff}) !==
          128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
         $display("%0t: predictor expected %h actual %h", $realtime,
                  128'h69c4e0d86a7b0430d8cdb78070b4c55a,
                  encrypt_block({64'h0011223344556677, 64'h8899aabbccddeeff}));
         errors++;
      end
   endtask

   // extreme keys and plaintexts, walking bits, unknown register index
   task automatic test_extremes();
      load_key('1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h1);
      load_key('0, '1);
      send_block('1, '0);
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
      write_key_reg(CsrIdxW'(5), 64'hdeadbeefdeadbeef);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      load_key(64'h1, 64'h8000000000000000);
      for (int i = 0; i < 8; i++) send_block(64'h1 << (8 * i + i), 64'h1 << (63 - 8 * i));
   endtask

   // bursts of random blocks under several random keys
   task automatic test_random_bursts(input int total);
      int left;
      int burst;
      left = total;
      stall_random = 1'b1;
      while (left > 0) begin
         if ($urandom_range(0, 199) == 0) load_key(rand64(), rand64());
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_block(rand64(), rand64());
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(0, 12));
      end
   endtask

   // long receiver hold-off with the sender pushing, then a full drain and a further run under random stalls
   task automatic test_backpressure();
      stall_random = 1'b0;
      @(negedge clock);
      hold_left = 200;
      for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
      wait_drained();
      stall_random = 1'b1;
      for (int i = 0; i < 30; i++) send_block(rand64(), rand64());
   endtask

   initial begin
      build_sub_lut();
      key_hi_q = '0;
      key_lo_q = '0;
      expand_round_keys();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (KeySettle) @(posedge clock);
      test_standard_vector();
      test_extremes();
      test_random_bursts(600);
      test_backpressure();
      load_key('1, 64'h0);
      test_random_bursts(600);
      wait_drained();
      $display("covered %0d blocks and %0d results across %0d register writes,",
               blocks_sent, ciphers_seen, keys_used);
      $display("with random stalls, bursts and a long output hold-off");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
